>>> rtl/sqb_pkg.sv
// ----------------------------------------------------------------------------
// sqb_pkg
// Shared widths, codes and the corner order table of the sprite quad batcher.
// ----------------------------------------------------------------------------
package sqb_pkg;

  localparam int unsigned MAX_SPRITES = 1024;
  localparam int unsigned CNT_W       = $clog2(MAX_SPRITES + 1);

  localparam int unsigned OPA_W  = 18;  // signed multiplier operand a
  localparam int unsigned OPB_W  = 29;  // signed multiplier operand b
  localparam int unsigned PROD_W = OPA_W + OPB_W;
  localparam int unsigned SIZE_W = 28;  // sprite size, Q.12 unsigned
  localparam int unsigned TERM_W = 44;  // one linear term, signed
  localparam int unsigned UV_W   = 17;
  localparam int unsigned VIDX_W = 13;
  localparam int unsigned BCNT_W = 11;

  localparam logic [UV_W-1:0] UV_MAX = '1;

  localparam logic [1:0] ACT_DRAW  = 2'd0;
  localparam logic [1:0] ACT_END   = 2'd1;
  localparam logic [1:0] ACT_BEGIN = 2'd2;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  // which linear terms a corner uses: bit use_x picks the width term,
  // use_y the height term
  typedef struct packed {
    logic use_y;
    logic use_x;
  } corner_t;

  // triangle order 0,1,2,2,1,3
  function automatic corner_t corner_of(input logic [2:0] slot);
    corner_t c;
    c = '0;
    unique case (slot)
      3'd0:    c = '{use_y: 1'b0, use_x: 1'b0};
      3'd1:    c = '{use_y: 1'b0, use_x: 1'b1};
      3'd2:    c = '{use_y: 1'b1, use_x: 1'b0};
      3'd3:    c = '{use_y: 1'b1, use_x: 1'b0};
      3'd4:    c = '{use_y: 1'b0, use_x: 1'b1};
      3'd5:    c = '{use_y: 1'b1, use_x: 1'b1};
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/sqb_mul.sv
// ----------------------------------------------------------------------------
// sqb_mul
// Shared signed multiplier used by the sequencer for sizes and linear terms.
// ----------------------------------------------------------------------------
module sqb_mul (
  input  logic signed [sqb_pkg::OPA_W-1:0]  op_a_i,
  input  logic signed [sqb_pkg::OPB_W-1:0]  op_b_i,
  output logic signed [sqb_pkg::PROD_W-1:0] prod_o
);
  import sqb_pkg::*;

  logic signed [PROD_W-1:0] a_ext;
  logic signed [PROD_W-1:0] b_ext;

  assign a_ext  = PROD_W'(op_a_i);
  assign b_ext  = PROD_W'(op_b_i);
  assign prod_o = a_ext * b_ext;

endmodule

>>> rtl/sqb_vtx.sv
// ----------------------------------------------------------------------------
// sqb_vtx
// One position axis of a corner: sum of the selected linear terms, rounded
// to integer Q.12, translated and saturated to 32 bits.
// ----------------------------------------------------------------------------
module sqb_vtx (
  input  sqb_pkg::corner_t                 corner_i,
  input  logic signed [sqb_pkg::TERM_W-1:0] term_x_i,
  input  logic signed [sqb_pkg::TERM_W-1:0] term_y_i,
  input  logic signed [31:0]                trans_i,
  output logic signed [31:0]                pos_o
);
  import sqb_pkg::*;

  localparam int unsigned SUM_W = TERM_W + 3;

  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    tx_ext;
  logic signed [SUM_W-1:0]    ty_ext;
  logic signed [SUM_W-1:0]    tr_ext;
  logic signed [SUM_W-13:0]   shifted;

  assign tx_ext = corner_i.use_x ? SUM_W'(term_x_i) : '0;
  assign ty_ext = corner_i.use_y ? SUM_W'(term_y_i) : '0;
  // translation is a multiple of 4096 here, so it folds into the rounding sum
  assign tr_ext = {{(SUM_W-44){trans_i[31]}}, trans_i, 12'd0};
  assign sum    = tx_ext + ty_ext + tr_ext + SUM_W'(2048);
  assign shifted = sum[SUM_W-1:12];

  always_comb begin
    if (shifted[SUM_W-13:31] == '0 || shifted[SUM_W-13:31] == '1) begin
      pos_o = shifted[31:0];
    end else if (shifted[SUM_W-13]) begin
      pos_o = 32'sh8000_0000;
    end else begin
      pos_o = 32'sh7FFF_FFFF;
    end
  end

endmodule

>>> rtl/sprite_quad_batcher.sv
// ----------------------------------------------------------------------------
// sprite_quad_batcher
// Expands textured sprites into two-triangle quads and closes batches with
// flush markers when the key changes, the batch fills, or on end.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (valid/ready) carry a draw, begin or end command. Output
//   words (valid/ready) carry vertices (kind 0) or flush markers (kind 1);
//   last marks the final word caused by an input word.
//   A textured draw runs six passes through the one shared multiplier (two
//   sizes, four linear terms), then emits one word a cycle while the receiver
//   takes them: an optional flush marker and six vertices. An end with a
//   pending batch emits one flush marker. Begin, untextured draws, unused
//   codes and an end with no pending batch emit nothing.
//   The output register lets the next input word be accepted while the last
//   result still waits. A stalled receiver holds the output word and pauses
//   emission; the sequencer waits with it.
//   Reset clears the sprite count and key; no word is pending afterwards.
// ----------------------------------------------------------------------------
module sprite_quad_batcher (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic        has_texture_i,
  input  logic [15:0] batch_key_i,
  input  logic [14:0] tex_width_i,
  input  logic [14:0] tex_height_i,
  input  logic [31:0] rect_pos_i,
  input  logic [33:0] rect_size_i,
  input  logic [63:0] mat_linear_i,
  input  logic signed [31:0] mat_tx_i,
  input  logic signed [31:0] mat_ty_i,
  input  logic [31:0] color_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic [sqb_pkg::UV_W-1:0]   tex_u_o,
  output logic [sqb_pkg::UV_W-1:0]   tex_v_o,
  output logic [31:0] vertex_color_o,
  output logic [sqb_pkg::VIDX_W-1:0] vertex_index_o,
  output logic [sqb_pkg::BCNT_W-1:0] batch_sprites_o,
  output logic [15:0] flushed_key_o,
  output logic        last_o
);
  import sqb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_EMIT
  } state_e;

  localparam logic [2:0] MUL_SX   = 3'd0;
  localparam logic [2:0] MUL_SY   = 3'd1;
  localparam logic [2:0] MUL_PA   = 3'd2;
  localparam logic [2:0] MUL_PB   = 3'd3;
  localparam logic [2:0] MUL_PC   = 3'd4;
  localparam logic [2:0] MUL_PD   = 3'd5;
  localparam logic [2:0] SLOT_END = 3'd5;

  state_e            state_q;
  logic [2:0]        step_q;
  logic [2:0]        slot_q;
  logic [CNT_W-1:0]  count_q;
  logic [15:0]       cur_key_q;
  logic [VIDX_W-1:0] vbase_q;
  logic              flush_pend_q;
  logic              has_verts_q;
  logic [BCNT_W-1:0] flush_cnt_q;
  logic [15:0]       flush_key_q;
  logic [VIDX_W-1:0] spr_base_q;

  // captured sprite payload and intermediate results
  logic [14:0]              tw_q, th_q;
  logic [16:0]              rw_q, rh_q;
  logic signed [15:0]       ma_q, mb_q, mc_q, md_q;
  logic signed [31:0]       tx_q, ty_q;
  logic [UV_W-1:0]          left_q, top_q, right_q, bottom_q;
  logic [31:0]              color_q;
  logic [SIZE_W-1:0]        sx_q, sy_q;
  logic signed [TERM_W-1:0] pa_q, pb_q, pc_q, pd_q;

  logic              accept;
  logic              is_draw;
  logic              need_flush;
  logic              emit_go;
  logic [BCNT_W-1:0] count_bc;
  logic [CNT_W+BCNT_W-1:0] count_wide;
  logic [17:0]       right_sum, bottom_sum;

  logic signed [OPA_W-1:0]  op_a;
  logic signed [OPB_W-1:0]  op_b;
  logic signed [PROD_W-1:0] prod;
  corner_t                  corner;
  logic signed [31:0]       vx, vy;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_draw    = (action_i == ACT_DRAW) && has_texture_i;
  assign need_flush = (count_q != '0) &&
                      ((count_q >= CNT_W'(MAX_SPRITES)) || (cur_key_q != batch_key_i));
  assign emit_go    = (state_q == ST_EMIT) && (!out_valid_o || out_ready_i);
  assign count_wide = {{BCNT_W{1'b0}}, count_q};
  assign count_bc   = count_wide[BCNT_W-1:0];

  assign right_sum  = 18'(rect_pos_i[15:0]) + 18'(rect_size_i[16:0]);
  assign bottom_sum = 18'(rect_pos_i[31:16]) + 18'(rect_size_i[33:17]);

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (step_q)
      MUL_SX: begin
        op_a = OPA_W'({1'b0, rw_q});
        op_b = OPB_W'({1'b0, tw_q});
      end
      MUL_SY: begin
        op_a = OPA_W'({1'b0, rh_q});
        op_b = OPB_W'({1'b0, th_q});
      end
      MUL_PA: begin
        op_a = OPA_W'(ma_q);
        op_b = OPB_W'({1'b0, sx_q});
      end
      MUL_PB: begin
        op_a = OPA_W'(mb_q);
        op_b = OPB_W'({1'b0, sy_q});
      end
      MUL_PC: begin
        op_a = OPA_W'(mc_q);
        op_b = OPB_W'({1'b0, sx_q});
      end
      MUL_PD: begin
        op_a = OPA_W'(md_q);
        op_b = OPB_W'({1'b0, sy_q});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  sqb_mul u_mul (
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  assign corner = corner_of(slot_q);

  sqb_vtx u_vtx_x (
    .corner_i (corner),
    .term_x_i (pa_q),
    .term_y_i (pb_q),
    .trans_i  (tx_q),
    .pos_o    (vx)
  );

  sqb_vtx u_vtx_y (
    .corner_i (corner),
    .term_x_i (pc_q),
    .term_y_i (pd_q),
    .trans_i  (ty_q),
    .pos_o    (vy)
  );

  // payload capture and multiplier results
  always_ff @(posedge clk_i) begin
    if (accept) begin
      tw_q     <= tex_width_i;
      th_q     <= tex_height_i;
      rw_q     <= rect_size_i[16:0];
      rh_q     <= rect_size_i[33:17];
      ma_q     <= mat_linear_i[15:0];
      mb_q     <= mat_linear_i[31:16];
      mc_q     <= mat_linear_i[47:32];
      md_q     <= mat_linear_i[63:48];
      tx_q     <= mat_tx_i;
      ty_q     <= mat_ty_i;
      color_q  <= color_i;
      left_q   <= UV_W'(rect_pos_i[15:0]);
      top_q    <= UV_W'(rect_pos_i[31:16]);
      right_q  <= (right_sum > 18'(UV_MAX)) ? UV_MAX : right_sum[UV_W-1:0];
      bottom_q <= (bottom_sum > 18'(UV_MAX)) ? UV_MAX : bottom_sum[UV_W-1:0];
    end
    if (state_q == ST_MUL) begin
      unique case (step_q)
        MUL_SX:  sx_q <= prod[SIZE_W+3:4];
        MUL_SY:  sy_q <= prod[SIZE_W+3:4];
        MUL_PA:  pa_q <= prod[TERM_W-1:0];
        MUL_PB:  pb_q <= prod[TERM_W-1:0];
        MUL_PC:  pc_q <= prod[TERM_W-1:0];
        MUL_PD:  pd_q <= prod[TERM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      step_q          <= '0;
      slot_q          <= '0;
      count_q         <= '0;
      cur_key_q       <= '0;
      vbase_q         <= '0;
      flush_pend_q    <= 1'b0;
      has_verts_q     <= 1'b0;
      flush_cnt_q     <= '0;
      flush_key_q     <= '0;
      spr_base_q      <= '0;
      out_valid_o     <= 1'b0;
      kind_o          <= KIND_VERTEX;
      pos_x_o         <= '0;
      pos_y_o         <= '0;
      tex_u_o         <= '0;
      tex_v_o         <= '0;
      vertex_color_o  <= '0;
      vertex_index_o  <= '0;
      batch_sprites_o <= '0;
      flushed_key_o   <= '0;
      last_o          <= 1'b0;
    end else begin
      // drop the word once taken unless the next one replaces it
      if (out_valid_o && out_ready_i && !emit_go) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            flush_cnt_q <= count_bc;
            flush_key_q <= cur_key_q;
            priority if (action_i == ACT_BEGIN) begin
              count_q <= '0;
              vbase_q <= '0;
            end else if (action_i == ACT_END) begin
              if (count_q != '0) begin
                flush_pend_q <= 1'b1;
                has_verts_q  <= 1'b0;
                count_q      <= '0;
                vbase_q      <= '0;
                state_q      <= ST_EMIT;
              end
            end else if (is_draw) begin
              flush_pend_q <= need_flush;
              has_verts_q  <= 1'b1;
              step_q       <= MUL_SX;
              slot_q       <= '0;
              state_q      <= ST_MUL;
              if (count_q == '0 || need_flush) begin
                cur_key_q  <= batch_key_i;
                count_q    <= CNT_W'(1);
                vbase_q    <= VIDX_W'(6);
                spr_base_q <= '0;
              end else begin
                count_q    <= count_q + CNT_W'(1);
                vbase_q    <= vbase_q + VIDX_W'(6);
                spr_base_q <= vbase_q;
              end
            end
          end
        end
        ST_MUL: begin
          step_q <= step_q + 3'd1;
          if (step_q == MUL_PD) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_valid_o <= 1'b1;
            if (flush_pend_q) begin
              kind_o          <= KIND_FLUSH;
              pos_x_o         <= '0;
              pos_y_o         <= '0;
              tex_u_o         <= '0;
              tex_v_o         <= '0;
              vertex_color_o  <= '0;
              vertex_index_o  <= '0;
              batch_sprites_o <= flush_cnt_q;
              flushed_key_o   <= flush_key_q;
              last_o          <= !has_verts_q;
              flush_pend_q    <= 1'b0;
              if (!has_verts_q) begin
                state_q <= ST_IDLE;
              end
            end else begin
              kind_o          <= KIND_VERTEX;
              pos_x_o         <= vx;
              pos_y_o         <= vy;
              tex_u_o         <= corner.use_x ? right_q : left_q;
              tex_v_o         <= corner.use_y ? bottom_q : top_q;
              vertex_color_o  <= color_q;
              vertex_index_o  <= spr_base_q + VIDX_W'(slot_q);
              batch_sprites_o <= '0;
              flushed_key_o   <= '0;
              last_o          <= (slot_q == SLOT_END);
              slot_q          <= slot_q + 3'd1;
              if (slot_q == SLOT_END) begin
                state_q <= ST_IDLE;
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // the batch never grows past its limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_SPRITES))
    else $error("sprite count above batch limit");

  // a textured draw always blocks the input while it is expanded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_draw) |=> !in_ready_o)
    else $error("input ready right after a draw was accepted");

  // words of one item follow back to back once the receiver takes one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=> out_valid_o)
    else $error("gap inside the results of one item");

endmodule

>>> tb/sprite_quad_batcher_tb.sv
// ----------------------------------------------------------------------------
// sprite_quad_batcher_tb
// Self-checking bench for the sprite quad batcher. A short directed table
// covers commands, empty batches, ignored words and field extremes. Random
// draw/begin/end and unused-code traffic follows under several idle and stall
// mixes. Every output word is checked field by field against an in-bench model
// of the quad expansion and batching, or against the table's flush values.
// ----------------------------------------------------------------------------
module sprite_quad_batcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sqb_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int         UV_TOP     = 131071;
  // corner visited by each of the six vertex slots, two bits per slot
  localparam logic [11:0] CORNER_SEQ = {2'd3, 2'd1, 2'd2, 2'd2, 2'd1, 2'd0};

  typedef struct packed {
    logic [1:0]  action;
    logic        has_tex;
    logic [15:0] key;
    logic [14:0] tw;
    logic [14:0] th;
    logic [31:0] pos;
    logic [33:0] size;
    logic [63:0] lin;
    logic [31:0] tx;
    logic [31:0] ty;
    logic [31:0] color;
  } sprite_word_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [31:0] color;
    logic [12:0] vidx;
    logic [10:0] bcnt;
    logic [15:0] fkey;
    logic        last;
  } vertex_word_t;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_FLUSH} row_check_e;

  typedef struct packed {
    sprite_word_t w;
    row_check_e   chk;
    logic [10:0]  flush_cnt;
    logic [15:0]  flush_key;
  } table_row_t;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  act = '0;
  logic        has_tex = 1'b0;
  logic [15:0] bkey = '0;
  logic [14:0] twid = '0;
  logic [14:0] thgt = '0;
  logic [31:0] rpos = '0;
  logic [33:0] rsize = '0;
  logic [63:0] mlin = '0;
  logic [31:0] mtx = '0;
  logic [31:0] mty = '0;
  logic [31:0] col = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [UV_W-1:0]   tex_u;
  logic [UV_W-1:0]   tex_v;
  logic [31:0]       vcolor;
  logic [VIDX_W-1:0] vidx;
  logic [BCNT_W-1:0] bcnt;
  logic [15:0]       fkey;
  logic              last;

  sprite_quad_batcher DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .action_i       (act),
    .has_texture_i  (has_tex),
    .batch_key_i    (bkey),
    .tex_width_i    (twid),
    .tex_height_i   (thgt),
    .rect_pos_i     (rpos),
    .rect_size_i    (rsize),
    .mat_linear_i   (mlin),
    .mat_tx_i       (mtx),
    .mat_ty_i       (mty),
    .color_i        (col),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .kind_o         (kind),
    .pos_x_o        (pos_x),
    .pos_y_o        (pos_y),
    .tex_u_o        (tex_u),
    .tex_v_o        (tex_v),
    .vertex_color_o (vcolor),
    .vertex_index_o (vidx),
    .batch_sprites_o(bcnt),
    .flushed_key_o  (fkey),
    .last_o         (last)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // model state
  int           batch_cnt = 0;
  logic [15:0]  batch_key = '0;
  vertex_word_t quad_q[$];

  int idle_pct  = 0;
  int stall_pct = 0;
  int err_cnt   = 0;
  int words_in  = 0;
  int sprites   = 0;
  int vert_seen = 0;
  int flush_seen = 0;
  logic [15:0] key_pool [4];

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
      input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%08h want 0x%08h", name, got, want));
  endtask

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // round half toward plus infinity, then drop the 12 fraction bits
  function automatic longint round_q12(input longint v);
    return (v + 2048) >>> 12;
  endfunction

  function automatic vertex_word_t close_batch();
    vertex_word_t f;
    f = '0;
    f.kind = KIND_FLUSH;
    f.bcnt = batch_cnt[10:0];
    f.fkey = batch_key;
    batch_cnt = 0;
    return f;
  endfunction

  task automatic expand_word(input sprite_word_t w, input bit keep);
    vertex_word_t r[7];
    int n, k, ci, slot;
    longint sx, sy, a, b, c, d, tx, ty, cx, cy, lf, tp, rt, bt;
    logic [31:0] px[4], py[4];
    logic [16:0] pu[4], pv[4];
    n = 0;
    case (w.action)
      ACT_BEGIN: batch_cnt = 0;
      ACT_END: begin
        if (batch_cnt != 0) begin
          r[0] = close_batch();
          n = 1;
        end
      end
      ACT_DRAW: begin
        if (w.has_tex) begin
          if (batch_cnt == 0) begin
            batch_key = w.key;
          end else if (batch_cnt >= MAX_SPRITES || batch_key != w.key) begin
            r[0] = close_batch();
            n = 1;
            batch_key = w.key;
          end
          sx = (longint'(w.tw) * longint'(w.size[16:0])) >>> 4;
          sy = (longint'(w.th) * longint'(w.size[33:17])) >>> 4;
          a = $signed(w.lin[15:0]);
          b = $signed(w.lin[31:16]);
          c = $signed(w.lin[47:32]);
          d = $signed(w.lin[63:48]);
          tx = $signed(w.tx);
          ty = $signed(w.ty);
          lf = w.pos[15:0];
          tp = w.pos[31:16];
          rt = lf + longint'(w.size[16:0]);
          bt = tp + longint'(w.size[33:17]);
          if (rt > UV_TOP) rt = UV_TOP;
          if (bt > UV_TOP) bt = UV_TOP;
          for (k = 0; k < 4; k++) begin
            cx = ((k & 1) != 0) ? sx : 0;
            cy = ((k & 2) != 0) ? sy : 0;
            px[k] = clamp32(round_q12(a * cx + b * cy) + tx);
            py[k] = clamp32(round_q12(c * cx + d * cy) + ty);
            pu[k] = ((k & 1) != 0) ? rt[16:0] : lf[16:0];
            pv[k] = ((k & 2) != 0) ? bt[16:0] : tp[16:0];
          end
          for (k = 0; k < 6; k++) begin
            ci = CORNER_SEQ[2*k +: 2];
            slot = batch_cnt * 6 + k;
            r[n] = '0;
            r[n].kind  = KIND_VERTEX;
            r[n].pos_x = px[ci];
            r[n].pos_y = py[ci];
            r[n].tex_u = pu[ci];
            r[n].tex_v = pv[ci];
            r[n].color = w.color;
            r[n].vidx  = slot[12:0];
            n++;
          end
          batch_cnt++;
          sprites++;
        end
      end
      default: ;
    endcase
    if (n > 0) r[n-1].last = 1'b1;
    if (keep) begin
      for (k = 0; k < n; k++) quad_q.push_back(r[k]);
    end
  endtask

  task automatic send_word(input sprite_word_t w);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    act      <= w.action;
    has_tex  <= w.has_tex;
    bkey     <= w.key;
    twid     <= w.tw;
    thgt     <= w.th;
    rpos     <= w.pos;
    rsize    <= w.size;
    mlin     <= w.lin;
    mtx      <= w.tx;
    mty      <= w.ty;
    col      <= w.color;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    words_in++;
  endtask

  function automatic sprite_word_t draw_w(input logic [15:0] key, input logic [14:0] tw,
      input logic [14:0] th, input logic [31:0] pos, input logic [33:0] size,
      input logic [63:0] lin, input logic [31:0] tx, input logic [31:0] ty,
      input logic [31:0] color);
    sprite_word_t w;
    w = '{action: ACT_DRAW, has_tex: 1'b1, key: key, tw: tw, th: th, pos: pos,
          size: size, lin: lin, tx: tx, ty: ty, color: color};
    return w;
  endfunction

  function automatic logic [14:0] pick_tex();
    case ($urandom_range(7))
      0:       return 15'd0;
      1:       return 15'd16384;
      2, 3:    return 15'($urandom_range(64, 1));
      default: return 15'($urandom_range(16384));
    endcase
  endfunction

  function automatic logic [31:0] pick_shift();
    case ($urandom_range(7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'($urandom_range(8191)) - 32'd4096;
      default: return $urandom;
    endcase
  endfunction

  function automatic sprite_word_t rand_sprite(input logic [15:0] key);
    return draw_w(key, pick_tex(), pick_tex(), $urandom,
                  {2'($urandom_range(3)), 32'($urandom)}, {$urandom, $urandom},
                  pick_shift(), pick_shift(), $urandom);
  endfunction

  // random content with any action; the draw fields still vary
  function automatic sprite_word_t cmd_w(input logic [1:0] action, input logic tex);
    sprite_word_t w;
    w = rand_sprite(16'($urandom));
    w.action  = action;
    w.has_tex = tex;
    return w;
  endfunction

  function automatic table_row_t row(input sprite_word_t w, input row_check_e chk,
      input logic [10:0] cnt, input logic [15:0] key);
    table_row_t t;
    t = '{w: w, chk: chk, flush_cnt: cnt, flush_key: key};
    return t;
  endfunction

  // pick mostly keyed draws from a small pool so batches build up
  function automatic sprite_word_t rand_word();
    int p;
    p = $urandom_range(99);
    if (p < 62) return rand_sprite(key_pool[$urandom_range(3)]);
    if (p < 70) return rand_sprite(16'($urandom));
    if (p < 80) return cmd_w(ACT_END, 1'($urandom));
    if (p < 86) return cmd_w(ACT_BEGIN, 1'($urandom));
    if (p < 94) return cmd_w(ACT_DRAW, 1'b0);
    return cmd_w(ACT_UNUSED, 1'($urandom));
  endfunction

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  vertex_word_t mon_exp;
  always @(posedge clk_i) begin
    if (rst_n && out_valid && out_ready) begin
      if (kind == KIND_FLUSH) flush_seen++;
      else vert_seen++;
      if (quad_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind=%0d vidx=%0d", kind, vidx));
      end else begin
        mon_exp = quad_q.pop_front();
        check_field("kind", 32'(kind), 32'(mon_exp.kind));
        check_field("pos_x", pos_x, mon_exp.pos_x);
        check_field("pos_y", pos_y, mon_exp.pos_y);
        check_field("tex_u", 32'(tex_u), 32'(mon_exp.tex_u));
        check_field("tex_v", 32'(tex_v), 32'(mon_exp.tex_v));
        check_field("vertex_color", vcolor, mon_exp.color);
        check_field("vertex_index", 32'(vidx), 32'(mon_exp.vidx));
        check_field("batch_sprites", 32'(bcnt), 32'(mon_exp.bcnt));
        check_field("flushed_key", 32'(fkey), 32'(mon_exp.fkey));
        check_field("last", 32'(last), 32'(mon_exp.last));
      end
    end
  end

  initial begin
    table_row_t dir_rows[$];
    vertex_word_t f;
    int idle_set[4];
    int stall_set[4];
    int ph, useful;
    sprite_word_t w;

    idle_set  = '{0, 54, 0, 21};
    stall_set = '{0, 0, 54, 21};

    dir_rows.push_back(row(cmd_w(ACT_END, 1'b1), CHK_NONE, '0, '0));
    dir_rows.push_back(row(cmd_w(ACT_BEGIN, 1'b1), CHK_NONE, '0, '0));
    dir_rows.push_back(row(cmd_w(ACT_DRAW, 1'b0), CHK_NONE, '0, '0));
    dir_rows.push_back(row(cmd_w(ACT_UNUSED, 1'b1), CHK_NONE, '0, '0));
    dir_rows.push_back(row(draw_w(16'h1234, '0, '0, '0, '0, '0, '0, '0, '0),
                           CHK_MODEL, '0, '0));
    // positive extremes: positions and texture coordinates saturate high
    dir_rows.push_back(row(draw_w(16'h1234, 15'd16384, 15'd16384, '1, '1,
                                  64'h7FFF_7FFF_7FFF_7FFF, 32'h7FFF_FFFF,
                                  32'h7FFF_FFFF, '1), CHK_MODEL, '0, '0));
    dir_rows.push_back(row(draw_w(16'h1234, 15'd16384, 15'd16384, '1, '1,
                                  64'h8000_8000_8000_8000, 32'h8000_0000,
                                  32'h8000_0000, '0), CHK_MODEL, '0, '0));
    dir_rows.push_back(row(cmd_w(ACT_END, 1'b0), CHK_FLUSH, 11'd3, 16'h1234));
    dir_rows.push_back(row(cmd_w(ACT_END, 1'b1), CHK_NONE, '0, '0));
    dir_rows.push_back(row(rand_sprite(16'hFFFF), CHK_MODEL, '0, '0));
    dir_rows.push_back(row(rand_sprite(16'h0000), CHK_MODEL, '0, '0));
    dir_rows.push_back(row(cmd_w(ACT_BEGIN, 1'b0), CHK_NONE, '0, '0));
    dir_rows.push_back(row(rand_sprite(16'h5555), CHK_MODEL, '0, '0));
    dir_rows.push_back(row(cmd_w(ACT_DRAW, 1'b0), CHK_NONE, '0, '0));
    // unit scale on a tiny sprite: exercises rounding of odd halves
    dir_rows.push_back(row(draw_w(16'h5555, 15'd3, 15'd5, 32'h0001_FFFF, 34'h0_0002_8001,
                                  64'hFFFF_0001_0001_FFFF, 32'hFFFF_FFFF, 32'd1,
                                  32'hA5A5_5A5A), CHK_MODEL, '0, '0));
    dir_rows.push_back(row(cmd_w(ACT_END, 1'b1), CHK_FLUSH, 11'd2, 16'h5555));
    dir_rows.push_back(row(draw_w(16'hAAAA, 15'd100, 15'd200, 32'h4000_8000,
                                  34'h1_0000_8000, 64'h1000_0000_0000_1000, '0, '0,
                                  32'h1234_5678), CHK_MODEL, '0, '0));
    dir_rows.push_back(row(cmd_w(ACT_END, 1'b0), CHK_FLUSH, 11'd1, 16'hAAAA));

    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].w);
      expand_word(dir_rows[i].w, dir_rows[i].chk == CHK_MODEL);
      if (dir_rows[i].chk == CHK_FLUSH) begin
        f = '0;
        f.kind = KIND_FLUSH;
        f.bcnt = dir_rows[i].flush_cnt;
        f.fkey = dir_rows[i].flush_key;
        f.last = 1'b1;
        quad_q.push_back(f);
      end
    end

    for (ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_set[ph];
      stall_pct = stall_set[ph];
      foreach (key_pool[j]) key_pool[j] = 16'($urandom);
      useful = 0;
      while (useful < 65) begin
        w = rand_word();
        send_word(w);
        expand_word(w, 1'b1);
        if (w.action == ACT_END || w.action == ACT_BEGIN ||
            (w.action == ACT_DRAW && w.has_tex)) useful++;
      end
    end
    in_valid <= 1'b0;

    while (quad_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Sent %0d input words (%0d sprites), checked %0d vertices and %0d flushes",
             words_in, sprites, vert_seen, flush_seen);
    $display("Traffic ran with no idling, sender gaps, receiver stalls, and both");
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Timeout with %0d words still expected", quad_q.size());
    $display("Verification failed");
    $finish;
  end

endmodule
